@@ sv/bkd_pkg.sv @@
package bkd_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // field widths
  localparam int CAP_W  = 10;
  localparam int VOL_W  = 10;
  localparam int VAL_W  = 16;
  localparam int CNT_W  = 10;
  localparam int SUM_W  = 32;
  localparam int ADD_W  = VAL_W + CNT_W;
  localparam int IN_W   = 40;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;  // capture item fields, drop saturation flag on start
    logic clr_init;   // rewind clearing address
    logic clr_step;   // write zero at clearing address and advance
    logic j_init;     // load sweep index with capacity
    logic base_rd;    // read entry j, restart candidate walk
    logic cand_rd;    // read next candidate entry
    logic write_j;    // write best into entry j and step j down
    logic res_rd;     // read entry at capacity
    logic res_load;   // move read data into output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;   // clearing address at last entry
    logic start;      // captured item starts a new set
    logic skip;       // zero volume or zero count
    logic more;       // another candidate fits
    logic j_zero;     // sweep reached entry zero
    logic out_free;   // output register can take a result
  } status_t;

endpackage

@@ sv/bounded_knapsack_dp_core.sv @@
// Per item: a sweep over j = capacity down to 0 reads m_j = min(count, j/volume) candidates
// for each entry; zero volume or zero count skips the sweep; the start flag first clears all
// 1024 table entries, and a result waits in S_RES_WAIT until the output register is free.
// The sweep is bound by the single read port of the best-value table, at most one entry read per cycle.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset (rst, synchronous): capacity and flags cleared, then a pass over all 1024 entries
// zeroes the table with s_tready low; config writes are taken throughout.
module bounded_knapsack_dp_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [bkd_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [bkd_pkg::IN_W-1:0]  s_tdata,   // item_volume[9:0], item_value[25:10],
                                               // item_count[35:26], zero[39:36]
  input  logic                      s_tuser,   // starts_new_set
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [bkd_pkg::SUM_W-1:0] m_tdata,   // best_value[31:0]
  output logic                      m_tuser    // saturated
);

  bkd_pkg::cmd_t    cmd;
  bkd_pkg::status_t sts;
  logic             in_fire;

  assign in_fire = s_tvalid && s_tready;

  bkd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .sts      (sts),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  bkd_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_start    (s_tuser),
    .in_volume   (s_tdata[9:0]),
    .in_value    (s_tdata[25:10]),
    .in_count    (s_tdata[35:26]),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_best    (m_tdata),
    .out_sat     (m_tuser)
  );

  // clearing pass holds off input right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready during reset clearing pass");

  // one item at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("second item accepted while busy");

  // table write port never driven by clear and sweep together
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_step, cmd.write_j, cmd.res_load, cmd.load_item}))
    else $error("conflicting datapath commands");

  // result only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!m_tvalid || m_tready))
    else $error("pending result overwritten");

endmodule

@@ sv/bkd_ctrl.sv @@
module bkd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  bkd_pkg::status_t sts,
  output logic             in_ready,
  output bkd_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_START    = 4'd2;
  localparam logic [3:0] S_JINIT    = 4'd3;
  localparam logic [3:0] S_BASE     = 4'd4;
  localparam logic [3:0] S_CAND     = 4'd5;
  localparam logic [3:0] S_WRITE    = 4'd6;
  localparam logic [3:0] S_RES_RD   = 4'd7;
  localparam logic [3:0] S_RES_WAIT = 4'd8;

  logic [3:0] state, state_next;
  logic       in_item, in_item_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      in_item <= 1'b0;
    end else begin
      state   <= state_next;
      in_item <= in_item_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    in_item_next = in_item;
    cmd          = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = in_item ? S_JINIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_item = 1'b1;
          state_next    = S_START;
        end
      end
      S_START: begin
        if (sts.start) begin
          cmd.clr_init = 1'b1;
          in_item_next = 1'b1;
          state_next   = S_CLEAR;
        end else begin
          state_next = S_JINIT;
        end
      end
      S_JINIT: begin
        cmd.j_init   = 1'b1;
        in_item_next = 1'b0;
        state_next   = sts.skip ? S_RES_RD : S_BASE;
      end
      S_BASE: begin
        cmd.base_rd = 1'b1;
        state_next  = S_CAND;
      end
      S_CAND: begin
        // issue candidates back to back; last read data lands here
        if (sts.more) begin
          cmd.cand_rd = 1'b1;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_j = 1'b1;
        state_next  = sts.j_zero ? S_RES_RD : S_BASE;
      end
      S_RES_RD: begin
        cmd.res_rd = 1'b1;
        state_next = S_RES_WAIT;
      end
      S_RES_WAIT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/bkd_dpath.sv @@
module bkd_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  bkd_pkg::cmd_t               cmd,
  output bkd_pkg::status_t            sts,
  input  logic                        cfg_wr_en,
  input  logic [bkd_pkg::CAP_W-1:0]   cfg_wr_data,
  input  logic                        in_start,
  input  logic [bkd_pkg::VOL_W-1:0]   in_volume,
  input  logic [bkd_pkg::VAL_W-1:0]   in_value,
  input  logic [bkd_pkg::CNT_W-1:0]   in_count,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [bkd_pkg::SUM_W-1:0]   out_best,
  output logic                        out_sat
);

  logic [bkd_pkg::SUM_W-1:0]  best_mem [bkd_pkg::TABLE_DEPTH];

  logic [bkd_pkg::CAP_W-1:0]  capacity;
  logic                       start;
  logic [bkd_pkg::VOL_W-1:0]  vol;
  logic [bkd_pkg::VAL_W-1:0]  val;
  logic [bkd_pkg::CNT_W-1:0]  cnt;
  logic [bkd_pkg::ADDR_W-1:0] clr_addr;
  logic [bkd_pkg::ADDR_W-1:0] j;
  logic [bkd_pkg::ADDR_W-1:0] cur;
  logic [bkd_pkg::CNT_W-1:0]  k;
  logic [bkd_pkg::ADD_W-1:0]  addval;
  logic [bkd_pkg::SUM_W-1:0]  best;
  logic                       ovf;
  logic                       pend;
  logic                       pend_base;
  logic [bkd_pkg::ADD_W-1:0]  pend_add;
  logic [bkd_pkg::SUM_W-1:0]  rd_data;

  logic [bkd_pkg::ADDR_W-1:0] cap_eff;
  logic [bkd_pkg::ADDR_W-1:0] cand_addr;
  logic [bkd_pkg::ADD_W-1:0]  addval_next;
  logic [bkd_pkg::ADDR_W-1:0] rd_addr;
  logic                       rd_en;
  logic [bkd_pkg::ADDR_W-1:0] wr_addr;
  logic [bkd_pkg::SUM_W-1:0]  wr_data;
  logic                       wr_en;
  logic [bkd_pkg::SUM_W:0]    sum;
  logic [bkd_pkg::SUM_W-1:0]  cand_val;

  // capacity already fits the table index
  assign cap_eff     = bkd_pkg::ADDR_W'(capacity);
  assign cand_addr   = cur - bkd_pkg::ADDR_W'(vol);
  assign addval_next = addval + bkd_pkg::ADD_W'(val);

  // status toward the controller
  assign sts.clr_last = (clr_addr == bkd_pkg::ADDR_W'(bkd_pkg::TABLE_DEPTH - 1));
  assign sts.start    = start;
  assign sts.skip     = (vol == '0) || (cnt == '0);
  assign sts.more     = (k < cnt) && (bkd_pkg::VOL_W'(cur) >= vol);
  assign sts.j_zero   = (j == '0);
  assign sts.out_free = !out_valid || out_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // capture item fields
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      start <= in_start;
      vol   <= in_volume;
      val   <= in_value;
      cnt   <= in_count;
    end
  end

  // clearing address
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_init) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // sweep index and candidate walk
  always_ff @(posedge clk) begin
    if (cmd.j_init) begin
      j <= cap_eff;
    end else if (cmd.write_j) begin
      j <= j - 1'b1;
    end
    if (cmd.base_rd) begin
      cur    <= j;
      k      <= '0;
      addval <= '0;
    end else if (cmd.cand_rd) begin
      cur    <= cand_addr;
      k      <= k + 1'b1;
      addval <= addval_next;
    end
  end

  // tag of the read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.base_rd || cmd.cand_rd;
    end
    pend_base <= cmd.base_rd;
    pend_add  <= addval_next;
  end

  // candidate sum with clamp
  assign sum      = {1'b0, rd_data} + (bkd_pkg::SUM_W + 1)'(pend_add);
  assign cand_val = sum[bkd_pkg::SUM_W] ? '1 : sum[bkd_pkg::SUM_W-1:0];

  // fold returned entry into running best
  always_ff @(posedge clk) begin
    if (pend) begin
      if (pend_base) begin
        best <= rd_data;
      end else if (cand_val > best) begin
        best <= cand_val;
      end
    end
  end

  // saturation flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else if (cmd.load_item && in_start) begin
      ovf <= 1'b0;
    end else if (pend && !pend_base && sum[bkd_pkg::SUM_W]) begin
      ovf <= 1'b1;
    end
  end

  // memory ports
  assign rd_en   = cmd.base_rd || cmd.cand_rd || cmd.res_rd;
  assign rd_addr = cmd.base_rd ? j : (cmd.cand_rd ? cand_addr : cap_eff);
  assign wr_en   = cmd.clr_step || cmd.write_j;
  assign wr_addr = cmd.clr_step ? clr_addr : j;
  assign wr_data = cmd.clr_step ? '0 : best;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      best_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= best_mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_best <= rd_data;
      out_sat  <= ovf;
    end
  end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected transfer on the result side
  typedef struct {
    logic [bkd_pkg::SUM_W-1:0] best;
    logic                      sat;
  } best_result_t;

  // Tracks the best-value table and flags the oldest expected result
  class best_value_tracker;
    logic [bkd_pkg::SUM_W-1:0] best_tbl [bkd_pkg::TABLE_DEPTH];
    bit                        sat_seen;
    logic [bkd_pkg::CAP_W-1:0] cap;
    best_result_t              expected_best [$];
    int                        fails;

    function new();
      foreach (best_tbl[i]) best_tbl[i] = '0;
      sat_seen = 1'b0;
      cap      = '0;
      fails    = 0;
    endfunction

    function void set_capacity(logic [bkd_pkg::CAP_W-1:0] c);
      cap = c;
    endfunction

    // Apply one accepted item to the table and queue the value at capacity
    function void take_item(bit start, logic [bkd_pkg::VOL_W-1:0] vol,
                            logic [bkd_pkg::VAL_W-1:0] val,
                            logic [bkd_pkg::CNT_W-1:0] cnt);
      int                        eff;
      int                        v;
      int                        n;
      longint unsigned           sum;
      logic [bkd_pkg::SUM_W-1:0] best;
      best_result_t              r;
      eff = int'(cap);
      if (eff > bkd_pkg::TABLE_DEPTH - 1) eff = bkd_pkg::TABLE_DEPTH - 1;
      v = int'(vol);
      n = int'(cnt);
      if (start) begin
        foreach (best_tbl[i]) best_tbl[i] = '0;
        sat_seen = 1'b0;
      end
      // sweep downward so every read below j still holds the old entry
      if (v != 0 && n != 0) begin
        for (int j = eff; j >= 0; j--) begin
          best = best_tbl[j];
          for (int k = 1; k <= n && k * v <= j; k++) begin
            sum = longint'(best_tbl[j - k * v]) + longint'(k) * longint'(val);
            if (sum > longint'({bkd_pkg::SUM_W{1'b1}})) begin
              sum      = longint'({bkd_pkg::SUM_W{1'b1}});
              sat_seen = 1'b1;
            end
            if (sum > longint'(best)) best = sum[bkd_pkg::SUM_W-1:0];
          end
          best_tbl[j] = best;
        end
      end
      r.best = best_tbl[eff];
      r.sat  = sat_seen;
      expected_best.push_back(r);
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(logic [bkd_pkg::SUM_W-1:0] best, logic sat);
      best_result_t r;
      if (expected_best.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: unexpected result best=%0d sat=%0b", best, sat);
        return;
      end
      r = expected_best.pop_front();
      if (best !== r.best || sat !== r.sat) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: best exp=%0d got=%0d, sat exp=%0b got=%0b",
                   r.best, best, r.sat, sat);
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [bkd_pkg::CAP_W-1:0] cfg_wr_data;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [bkd_pkg::IN_W-1:0]  s_tdata;
  logic                      s_tuser;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [bkd_pkg::SUM_W-1:0] m_tdata;
  logic                      m_tuser;

  best_value_tracker tracker = new();
  int                tx_gap_max = 13;
  int                rx_gap_max = 13;

  bounded_knapsack_dp_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic push_item(bit start, logic [bkd_pkg::VOL_W-1:0] vol,
                           logic [bkd_pkg::VAL_W-1:0] val,
                           logic [bkd_pkg::CNT_W-1:0] cnt);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= start;
    s_tdata  <= {{(bkd_pkg::IN_W - bkd_pkg::VOL_W - bkd_pkg::VAL_W - bkd_pkg::CNT_W){1'b0}},
                 cnt, val, vol};
    do @(posedge clk); while (!s_tready);
    tracker.take_item(start, vol, val, cnt);
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic drain;
    s_tvalid <= 1'b0;
    while (tracker.expected_best.size() != 0) @(posedge clk);
  endtask

  // Write the capacity register while the block is idle
  task automatic set_capacity(logic [bkd_pkg::CAP_W-1:0] c);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.set_capacity(c);
  endtask

  // Random item; with a large capacity keep volumes large so sweeps stay short
  task automatic random_item(bit big_cap);
    bit                        start;
    logic [bkd_pkg::VOL_W-1:0] vol;
    logic [bkd_pkg::CNT_W-1:0] cnt;
    logic [bkd_pkg::VAL_W-1:0] val;
    start = ($urandom_range(0, 5) == 0);
    if (big_cap) begin
      vol = bkd_pkg::VOL_W'($urandom_range(256, 1023));
      cnt = bkd_pkg::CNT_W'($urandom_range(0, 1023));
    end else begin
      vol = ($urandom_range(0, 9) < 7) ? bkd_pkg::VOL_W'($urandom_range(1, 12))
                                       : bkd_pkg::VOL_W'($urandom_range(0, 1023));
      cnt = ($urandom_range(0, 3) == 0) ? bkd_pkg::CNT_W'($urandom_range(0, 1023))
                                        : bkd_pkg::CNT_W'($urandom_range(1, 6));
    end
    val = bkd_pkg::VAL_W'($urandom_range(0, 65535));
    push_item(start, vol, val, cnt);
  endtask

  // Result side: random stalls, check each transfer
  initial begin
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, rx_gap_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      tracker.check_result(m_tdata, m_tuser);
    end
  end

  // Stimulus
  initial begin
    bit big;
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // zero capacity: nothing ever fits
    set_capacity(10'd0);
    push_item(1'b1, 10'd1, 16'hFFFF, 10'd1);
    push_item(1'b0, 10'd1023, 16'h1234, 10'd1023);

    // full table depth, large volumes, zero volume and zero count
    set_capacity(10'd1023);
    push_item(1'b1, 10'd1023, 16'hFFFF, 10'd1023);
    push_item(1'b0, 10'd512, 16'hAAAA, 10'd1);
    push_item(1'b0, 10'd341, 16'h5555, 10'd3);
    push_item(1'b0, 10'd0, 16'hFFFF, 10'd5);
    push_item(1'b0, 10'd7, 16'h0001, 10'd0);
    push_item(1'b0, 10'd1, 16'hFFFF, 10'd1);
    push_item(1'b0, 10'd2, 16'h8000, 10'd2);
    push_item(1'b1, 10'd1023, 16'h0000, 10'd1023);
    push_item(1'b0, 10'd256, 16'hFFFF, 10'd1023);
    push_item(1'b0, 10'h2AA, 16'h0001, 10'h155);
    push_item(1'b0, 10'h155, 16'hFFFE, 10'h2AA);

    // small capacity, counts well past what fits
    set_capacity(10'd37);
    push_item(1'b1, 10'd1, 16'hFFFF, 10'd1023);
    push_item(1'b0, 10'd5, 16'hFFFF, 10'd2);
    push_item(1'b0, 10'd3, 16'h7FFF, 10'd20);
    push_item(1'b1, 10'd38, 16'hFFFF, 10'd1);

    // random phases; one with a full-depth capacity
    for (int p = 0; p < 6; p++) begin
      big = (p == 3);
      set_capacity(big ? 10'd1023 : 10'($urandom_range(1, 63)));
      for (int i = 0; i < 16; i++) random_item(big);
    end

    drain();
    repeat (50) @(posedge clk);
    if (tracker.fails == 0 && tracker.expected_best.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

endmodule
